FILE: rtl/dtt_pkg.sv
`timescale 1ns / 1ps

package dtt_pkg;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_DIV    = 2'd0,
    REG_COUNT  = 2'd1,
    REG_RELOAD = 2'd2,
    REG_CTRL   = 2'd3
  } reg_idx_e;

  localparam int unsigned DataW    = 8;
  localparam int unsigned CyclesW  = 8;
  localparam int unsigned SubW     = 9;
  localparam int unsigned CdownW   = 12;
  localparam int unsigned EnableBit = 2;

  localparam logic [DataW-1:0]  DivReset   = 8'hAC;
  localparam logic [DataW-1:0]  CounterMax = 8'hFF;
  localparam logic [CdownW-1:0] CdownReset = 12'd1024;

  typedef struct packed {
    mode_e                mode;
    reg_idx_e             reg_index;
    logic [DataW-1:0]     write_data;
    logic [CyclesW-1:0]   elapsed_cycles;
  } in_item_t;

  // countdown period selected by the rate bits
  function automatic logic [CdownW-1:0] period_of(input logic [1:0] rate);
    logic [CdownW-1:0] p;
    case (rate)
      2'd0:    p = 12'd1024;
      2'd1:    p = 12'd16;
      2'd2:    p = 12'd64;
      default: p = 12'd256;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/dtt_if.sv
`timescale 1ns / 1ps

interface dtt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] reg_index;
  logic [7:0] write_data;
  logic [7:0] elapsed_cycles;

  modport source (output valid, output mode, output reg_index, output write_data,
                  output elapsed_cycles, input ready);
  modport sink   (input valid, input mode, input reg_index, input write_data,
                  input elapsed_cycles, output ready);
endinterface

interface dtt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       timer_irq;

  modport source (output valid, output read_data, output timer_irq, input ready);
  modport sink   (input valid, input read_data, input timer_irq, output ready);
endinterface

FILE: rtl/divider_and_tick_timer.sv
`timescale 1ns / 1ps
// path from an input transfer to its result transfer:
// one input register, one result register
// throughput: one item per cycle while the output is not stalled; the only loop is
// the timer state update, done combinationally between input and result registers
// reset: divider 0xac, countdown 1024, other timer registers and both valids cleared
module divider_and_tick_timer (
  input  logic      clk_i,
  input  logic      rst_ni,
  dtt_in_if.sink    in_i,
  dtt_out_if.source out_o
);
  import dtt_pkg::*;

  // input stage
  logic     in_vld_q;
  in_item_t in_q;
  logic     advance;

  // timer state
  logic [DataW-1:0]  div_q, div_d;
  logic [SubW-1:0]   sub_q, sub_d;
  logic [DataW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0]  reload_q, reload_d;
  logic [DataW-1:0]  ctrl_q, ctrl_d;
  logic [CdownW-1:0] cdown_q, cdown_d;

  // result stage
  logic             out_vld_q;
  logic [DataW-1:0] rd_q, rd_d;
  logic             irq_q, irq_d;

  logic [SubW-1:0]   sub_sum;
  logic [CdownW-1:0] cdown_diff;

  assign advance  = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.mode           <= mode_e'(in_i.mode);
      in_q.reg_index      <= reg_idx_e'(in_i.reg_index);
      in_q.write_data     <= in_i.write_data;
      in_q.elapsed_cycles <= in_i.elapsed_cycles;
    end
  end

  assign sub_sum    = sub_q + SubW'(in_q.elapsed_cycles);
  assign cdown_diff = cdown_q - CdownW'(in_q.elapsed_cycles);

  always_comb begin
    div_d    = div_q;
    sub_d    = sub_q;
    cnt_d    = cnt_q;
    reload_d = reload_q;
    ctrl_d   = ctrl_q;
    cdown_d  = cdown_q;
    rd_d     = '0;
    irq_d    = 1'b0;
    case (in_q.mode)
      MODE_TICK: begin
        if (sub_sum[SubW-1]) begin
          sub_d = '0;
          div_d = div_q + 8'd1;
        end else begin
          sub_d = sub_sum;
        end
        if (ctrl_q[EnableBit]) begin
          // countdown hit zero or went negative
          if (cdown_diff[CdownW-1] || cdown_diff == '0) begin
            cdown_d = period_of(ctrl_q[1:0]);
            if (cnt_q == CounterMax) begin
              cnt_d = reload_q;
              irq_d = 1'b1;
            end else begin
              cnt_d = cnt_q + 8'd1;
            end
          end else begin
            cdown_d = cdown_diff;
          end
        end
      end
      MODE_READ: begin
        case (in_q.reg_index)
          REG_DIV:    rd_d = div_q;
          REG_COUNT:  rd_d = cnt_q;
          REG_RELOAD: rd_d = reload_q;
          default:    rd_d = ctrl_q;
        endcase
      end
      MODE_WRITE: begin
        case (in_q.reg_index)
          REG_DIV: begin
            div_d = '0;
            sub_d = '0;
          end
          REG_COUNT:  cnt_d    = in_q.write_data;
          REG_RELOAD: reload_d = in_q.write_data;
          default: begin
            ctrl_d = in_q.write_data;
            if (in_q.write_data[1:0] != ctrl_q[1:0]) begin
              cdown_d = period_of(in_q.write_data[1:0]);
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q    <= DivReset;
      sub_q    <= '0;
      cnt_q    <= '0;
      reload_q <= '0;
      ctrl_q   <= '0;
      cdown_q  <= CdownReset;
    end else if (advance) begin
      div_q    <= div_d;
      sub_q    <= sub_d;
      cnt_q    <= cnt_d;
      reload_q <= reload_d;
      ctrl_q   <= ctrl_d;
      cdown_q  <= cdown_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rd_q  <= rd_d;
      irq_q <= irq_d;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.read_data = rd_q;
  assign out_o.timer_irq = irq_q;

  // an interrupt result never carries read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && irq_q |-> rd_q == '0)
    else $error("irq result with nonzero read data");

  // the sub-counter always wraps before reaching 256
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sub_q[SubW-1])
    else $error("sub-counter out of range");

  // the stored countdown is always a positive period remainder
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cdown_q[CdownW-1] && cdown_q != '0 && cdown_q <= CdownReset)
    else $error("countdown out of range");

  // an overflow reloads the counter from the reload register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && irq_d |=> cnt_q == $past(reload_q))
    else $error("counter not reloaded on overflow");

endmodule
